>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lpcf_pkg.sv
// Shared constants, types and functions of the LPC cepstrum frame block.
// No dependencies.
package lpcf_pkg;

   localparam int FRAME_LEN   = 320;
   localparam int ORDER       = 12;
   localparam int SAMPLE_BITS = 16;

   localparam int SA_W   = $clog2(FRAME_LEN);
   localparam int IDX_W  = $clog2(ORDER + 1);
   localparam int CA_W   = IDX_W + 1;
   localparam int LAG_W  = 2 * SAMPLE_BITS + SA_W;
   localparam int SH_W   = $clog2(LAG_W);
   localparam int Q_FRAC = 28;
   localparam int R_W    = Q_FRAC;
   localparam int COEF_W = 32;
   localparam int ACC_W  = 64;
   localparam int CNT_W  = $clog2(ACC_W + 1);

   localparam logic [LAG_W-1:0]        NORM_LIMIT = LAG_W'(134217728);
   localparam logic [IDX_W-1:0]        ORDER_IDX  = IDX_W'(ORDER);
   localparam logic [SA_W-1:0]         FRAME_LAST = SA_W'(FRAME_LEN - 1);
   localparam logic [3:0]              LAST_INDEX = 4'(ORDER);
   localparam logic signed [ACC_W-1:0] MAX32      = 64'sd2147483647;
   localparam logic signed [ACC_W-1:0] MIN32      = -64'sd2147483648;

   typedef struct packed {
      logic [SA_W-1:0] addr_a;
      logic [SA_W-1:0] addr_b;
   } smp_rd_type;

   typedef struct packed {
      logic                     valid;
      logic signed [COEF_W-1:0] coeff;
      logic [3:0]               index;
      logic                     last;
      logic                     degenerate;
   } result_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] dividend;
      logic [R_W-1:0]          divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [COEF_W-1:0] r;
      if (v > MAX32) begin
         r = MAX32[COEF_W-1:0];
      end else if (v < MIN32) begin
         r = MIN32[COEF_W-1:0];
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/lpcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lpcf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 320
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> src/lpcf_div.sv
// Shared signed divider, one quotient bit per cycle, quotient truncated to zero.
// Depends on lpcf_pkg.
module lpcf_div import lpcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [R_W-1:0]   rem_ff, rem_in;
   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [R_W-1:0]   dvs_ff, dvs_in;
   logic             done_ff, done_in;
   logic [ACC_W-1:0] res_ff, res_in;
   logic [R_W:0]     trial;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      trial   = {rem_ff, quo_ff[ACC_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req.dividend[ACC_W-1];
         rem_in  = '0;
         quo_in  = req.dividend[ACC_W-1] ? -req.dividend : req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? R_W'(trial - {1'b0, dvs_ff}) : trial[R_W-1:0];
         quo_in = {quo_ff[ACC_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -{quo_ff[ACC_W-2:0], ge} : {quo_ff[ACC_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      res_ff <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = $signed(res_ff);

endmodule

>>> src/lpcf_core.sv
// Frame sequencer: autocorrelation, lag normalization, Levinson-Durbin and cepstrum.
// Holds predictor and cepstrum stores in RAM; depends on lpcf_pkg, lpcf_ram.
module lpcf_core import lpcf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   output smp_rd_type                    smp_rd,
   input  logic signed [SAMPLE_BITS-1:0] smp_a,
   input  logic signed [SAMPLE_BITS-1:0] smp_b,
   output result_type                    result,
   input  logic                          result_ready,
   output div_req_type                   div_req,
   input  div_rsp_type                   div_rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_AC, S_AC_DRAIN, S_NORM_INIT, S_NORM, S_LD_START, S_LD_CHECK,
      S_LD_ACC, S_LD_NUM, S_LD_DIV, S_LD_UPD, S_LD_ERR, S_CP_INIT, S_CP_TERM,
      S_CP_DIV, S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              ph_ff, ph_in;
   logic [SA_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic                    bank_ff, bank_in;
   logic                    deg_ff, deg_in;
   logic                    v1_ff, v1_in, v2_ff, v2_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic [LAG_W-1:0]        tmp_ff, tmp_in;
   logic [SH_W-1:0]         sh_ff, sh_in;
   logic signed [R_W-1:0]   e_ff, e_in;
   logic signed [R_W-1:0]   rq_ff, rq_in;
   logic signed [COEF_W-1:0] kq_ff, kq_in;
   logic signed [COEF_W-1:0] cval_ff, cval_in;
   logic signed [LAG_W-1:0] lag_ff [ORDER+1];
   logic                    lag_we;

   logic [IDX_W-1:0]        rsel;
   logic signed [LAG_W-1:0] lag_shift;
   logic signed [R_W-1:0]   r_cur;

   logic                     coef_we;
   logic [CA_W-1:0]          coef_wa, coef_ra;
   logic signed [COEF_W-1:0] coef_wd;
   logic [COEF_W-1:0]        coef_rd;
   logic                     cep_we;
   logic signed [COEF_W-1:0] cep_wd;
   logic [COEF_W-1:0]        cep_rd;

   logic signed [COEF_W-1:0]        a_rd, c_rd;
   logic signed [2*SAMPLE_BITS-1:0] m_ss;
   logic signed [COEF_W+R_W-1:0]    m_ar;
   logic signed [2*COEF_W-1:0]      m_ka, m_kk, m_ca;
   logic [R_W-1:0]                  e_u;
   logic signed [36:0]              f_val;
   logic [Q_FRAC:0]                 f_u;
   logic [R_W+Q_FRAC:0]             m_ef;
   logic signed [ACC_W-Q_FRAC-1:0]  cp_t;
   logic signed [IDX_W:0]           k_s;
   logic signed [ACC_W-Q_FRAC+IDX_W:0] m_tk;
   logic signed [ACC_W-1:0]         sum_v;
   logic [IDX_W+3:0]                idx_ext;

   assign a_rd      = $signed(coef_rd);
   assign c_rd      = $signed(cep_rd);
   assign lag_shift = lag_ff[rsel] >>> sh_ff;
   assign r_cur     = lag_shift[R_W-1:0];
   assign m_ss      = smp_a * smp_b;
   assign m_ar      = a_rd * rq_ff;
   assign m_ka      = kq_ff * a_rd;
   assign m_kk      = kq_ff * kq_ff;
   assign m_ca      = c_rd * a_rd;
   assign e_u       = e_ff;
   assign f_val     = 37'sd268435456 - $signed({1'b0, prod_ff[ACC_W-1:Q_FRAC]});
   assign f_u       = f_val[Q_FRAC:0];
   assign m_ef      = e_u * f_u;
   assign cp_t      = prod_ff[ACC_W-1:Q_FRAC];
   assign k_s       = $signed({1'b0, k_ff});
   assign m_tk      = cp_t * k_s;
   assign idx_ext   = {4'b0, i_ff};
   assign busy      = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      bank_in  = bank_ff;
      deg_in   = deg_ff;
      v1_in    = 1'b0;
      v2_in    = v1_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      tmp_in   = tmp_ff;
      sh_in    = sh_ff;
      e_in     = e_ff;
      rq_in    = rq_ff;
      kq_in    = kq_ff;
      cval_in  = cval_ff;
      lag_we   = 1'b0;
      rsel     = '0;
      sum_v    = '0;
      coef_we  = 1'b0;
      coef_wa  = {~bank_ff, i_ff};
      coef_wd  = '0;
      coef_ra  = {bank_ff, k_ff};
      cep_we   = 1'b0;
      cep_wd   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = e_ff;
      smp_rd.addr_a    = j_ff;
      smp_rd.addr_b    = j_ff + SA_W'(k_ff);
      result.valid      = 1'b0;
      result.coeff      = deg_ff ? '0 : cval_ff;
      result.index      = idx_ext[3:0];
      result.last       = i_ff == ORDER_IDX;
      result.degenerate = deg_ff;

      if (v1_ff) begin
         prod_in = ACC_W'(m_ss);
      end
      if (v2_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      case (state_ff)
         S_IDLE: begin
            v2_in = 1'b0;
            if (start) begin
               state_in = S_AC;
               j_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               deg_in   = 1'b0;
            end
         end
         S_AC: begin
            v1_in = 1'b1;
            if (j_ff == FRAME_LAST - SA_W'(k_ff)) begin
               state_in = S_AC_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_AC_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               lag_we = 1'b1;
               acc_in = '0;
               j_in   = '0;
               if (k_ff == ORDER_IDX) begin
                  state_in = S_NORM_INIT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_AC;
               end
            end
         end
         S_NORM_INIT: begin
            tmp_in   = lag_ff[0];
            sh_in    = '0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (tmp_ff >= NORM_LIMIT) begin
               tmp_in = tmp_ff >> 1;
               sh_in  = sh_ff + 1'b1;
            end else begin
               state_in = S_LD_START;
            end
         end
         S_LD_START: begin
            rsel     = '0;
            e_in     = r_cur;
            i_in     = IDX_W'(1);
            bank_in  = 1'b0;
            state_in = S_LD_CHECK;
         end
         S_LD_CHECK: begin
            if (e_ff <= 0) begin
               deg_in   = 1'b1;
               i_in     = IDX_W'(1);
               state_in = S_EMIT;
            end else begin
               acc_in   = '0;
               k_in     = IDX_W'(1);
               ph_in    = '0;
               state_in = (i_ff == IDX_W'(1)) ? S_LD_NUM : S_LD_ACC;
            end
         end
         S_LD_ACC: begin
            rsel = i_ff - k_ff;
            case (ph_ff)
               2'd0: begin
                  rq_in = r_cur;
                  ph_in = 2'd1;
               end
               2'd1: begin
                  prod_in = ACC_W'(m_ar);
                  ph_in   = 2'd2;
               end
               default: begin
                  acc_in = acc_ff + prod_ff;
                  ph_in  = 2'd0;
                  if (k_ff == i_ff - 1'b1) begin
                     state_in = S_LD_NUM;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         S_LD_NUM: begin
            rsel             = i_ff;
            div_req.start    = 1'b1;
            div_req.dividend = (ACC_W'(r_cur) <<< Q_FRAC) - acc_ff;
            div_req.divisor  = e_ff;
            state_in         = S_LD_DIV;
         end
         S_LD_DIV: begin
            if (div_rsp.done) begin
               kq_in    = sat32(div_rsp.quotient);
               coef_we  = 1'b1;
               coef_wa  = {~bank_ff, i_ff};
               coef_wd  = sat32(div_rsp.quotient);
               k_in     = IDX_W'(1);
               ph_in    = '0;
               state_in = (i_ff == IDX_W'(1)) ? S_LD_ERR : S_LD_UPD;
            end
         end
         S_LD_UPD: begin
            case (ph_ff)
               2'd0: begin
                  coef_ra = {bank_ff, i_ff - k_ff};
                  ph_in   = 2'd1;
               end
               2'd1: begin
                  coef_ra = {bank_ff, k_ff};
                  prod_in = m_ka;
                  ph_in   = 2'd2;
               end
               default: begin
                  sum_v   = ACC_W'(a_rd) - (prod_ff >>> Q_FRAC);
                  coef_we = 1'b1;
                  coef_wa = {~bank_ff, k_ff};
                  coef_wd = sat32(sum_v);
                  ph_in   = 2'd0;
                  if (k_ff == i_ff - 1'b1) begin
                     state_in = S_LD_ERR;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         S_LD_ERR: begin
            case (ph_ff)
               2'd0: begin
                  prod_in = m_kk;
                  ph_in   = 2'd1;
               end
               2'd1: begin
                  prod_in = (f_val > 0) ? ACC_W'(m_ef) : '0;
                  ph_in   = 2'd2;
               end
               default: begin
                  e_in    = prod_ff[R_W+Q_FRAC-1:Q_FRAC];
                  bank_in = ~bank_ff;
                  ph_in   = 2'd0;
                  if (i_ff == ORDER_IDX) begin
                     i_in     = IDX_W'(1);
                     state_in = S_CP_INIT;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_LD_CHECK;
                  end
               end
            endcase
         end
         S_CP_INIT: begin
            acc_in   = '0;
            k_in     = IDX_W'(1);
            ph_in    = '0;
            state_in = (i_ff == IDX_W'(1)) ? S_CP_DIV : S_CP_TERM;
         end
         S_CP_TERM: begin
            coef_ra = {bank_ff, i_ff - k_ff};
            case (ph_ff)
               2'd0: begin
                  ph_in = 2'd1;
               end
               2'd1: begin
                  prod_in = m_ca;
                  ph_in   = 2'd2;
               end
               2'd2: begin
                  prod_in = ACC_W'(m_tk);
                  ph_in   = 2'd3;
               end
               default: begin
                  acc_in = acc_ff + prod_ff;
                  ph_in  = 2'd0;
                  if (k_ff == i_ff - 1'b1) begin
                     state_in = S_CP_DIV;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         S_CP_DIV: begin
            coef_ra = {bank_ff, i_ff};
            if (ph_ff == 2'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = acc_ff;
               div_req.divisor  = R_W'(i_ff);
               ph_in            = 2'd1;
            end else if (div_rsp.done) begin
               sum_v    = ACC_W'(a_rd) + div_rsp.quotient;
               cep_we   = 1'b1;
               cep_wd   = sat32(sum_v);
               cval_in  = sat32(sum_v);
               ph_in    = 2'd0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            result.valid = 1'b1;
            if (result_ready) begin
               if (i_ff == ORDER_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = deg_ff ? S_EMIT : S_CP_INIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      bank_ff <= bank_in;
      deg_ff  <= deg_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      sh_ff   <= sh_in;
      e_ff    <= e_in;
      rq_ff   <= rq_in;
      kq_ff   <= kq_in;
      cval_ff <= cval_in;
      if (lag_we) begin
         lag_ff[k_ff] <= acc_ff[LAG_W-1:0];
      end
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
   end

   lpcf_ram #(.WIDTH(COEF_W), .DEPTH(2**CA_W)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wa),
      .wr_data (coef_wd),
      .rd_addr (coef_ra),
      .rd_data (coef_rd)
   );

   lpcf_ram #(.WIDTH(COEF_W), .DEPTH(2**IDX_W)) u_cep_ram (
      .clock   (clock),
      .wr_en   (cep_we),
      .wr_addr (i_ff),
      .wr_data (cep_wd),
      .rd_addr (k_ff),
      .rd_data (cep_rd)
   );

endmodule

>>> src/lpc_cepstrum_frame.sv
// Top level of the LPC cepstrum frame block: frame buffer, output register, core, divider.
// Depends on lpcf_pkg, lpcf_ram, lpcf_div, lpcf_core.
//
//   port group   direction   handshake           payload
//   req_         in          req_valid/stall     sample
//   rsp_         out         rsp_valid/stall     cepstral_coeff, coeff_index, last, degenerate
//
// Samples are taken one per cycle until the frame is full.
// The frame computation then stalls the input through autocorrelation, recursion and
// cepstrum; each division waits on the shared divider.
// Reset is synchronous and clears control state only; no clearing pass.
// A stalled result holds the sequencer before the next coefficient.
module lpc_cepstrum_frame import lpcf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COEF_W-1:0]      rsp_cepstral_coeff,
   output logic [3:0]                    rsp_coeff_index,
   output logic                          rsp_last_coeff,
   output logic                          rsp_degenerate_frame
);

   logic [SA_W-1:0]          count_ff, count_in;
   logic                     accept, start, busy, out_ready;
   smp_rd_type               smp_rd;
   logic [SAMPLE_BITS-1:0]   smp_a, smp_b;
   result_type               result;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COEF_W-1:0] coeff_ff;
   logic [3:0]               index_ff;
   logic                     last_ff, degen_ff;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign start     = accept && (count_ff == FRAME_LAST);
   assign count_in  = start ? '0 : (accept ? count_ff + 1'b1 : count_ff);
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid && out_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && out_ready) begin
         coeff_ff <= result.coeff;
         index_ff <= result.index;
         last_ff  <= result.last;
         degen_ff <= result.degenerate;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cepstral_coeff   = coeff_ff;
   assign rsp_coeff_index      = index_ff;
   assign rsp_last_coeff       = last_ff;
   assign rsp_degenerate_frame = degen_ff;

   lpcf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_LEN)) u_smp_ram_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff),
      .wr_data (req_sample),
      .rd_addr (smp_rd.addr_a),
      .rd_data (smp_a)
   );

   lpcf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FRAME_LEN)) u_smp_ram_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff),
      .wr_data (req_sample),
      .rd_addr (smp_rd.addr_b),
      .rd_data (smp_b)
   );

   lpcf_core u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .smp_rd       (smp_rd),
      .smp_a        ($signed(smp_a)),
      .smp_b        ($signed(smp_b)),
      .result       (result),
      .result_ready (out_ready),
      .div_req      (div_req),
      .div_rsp      (div_rsp)
   );

   lpcf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

>>> src/lpcf_checker.sv
// Port-level checker for the LPC cepstrum frame block, bound to the top level.
// Depends on lpcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpcf_checker import lpcf_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic signed [SAMPLE_BITS-1:0] req_sample,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COEF_W-1:0]      rsp_cepstral_coeff,
   input logic [3:0]                    rsp_coeff_index,
   input logic                          rsp_last_coeff,
   input logic                          rsp_degenerate_frame
);

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cepstral_coeff) && $stable(rsp_coeff_index), "stalled item changed")
   `ASSERT_RST(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate_frame |-> rsp_cepstral_coeff == '0, "degenerate item not zero")
   `ASSERT_RST(a_last_index, clock, reset, rsp_valid && rsp_last_coeff |-> rsp_coeff_index == LAST_INDEX, "last item has wrong index")
   `ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !req_stall, "input stalled after reset")

endmodule

bind lpc_cepstrum_frame lpcf_checker u_checker (.*);
